FILE: rtl/tak_pkg.sv
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter package
// Shared widths, command and state codes, saturation helpers.
// ----------------------------------------------------------------------------
package tak_pkg;

   localparam int DATA_W  = 32;
   localparam int FRAC_W  = 20;
   localparam int DT_W    = 21;
   localparam int NOISE_W = 21;
   localparam int MEAS_W  = 31;
   localparam int DVD_W   = DATA_W + FRAC_W;
   localparam int CNT_W   = 6;
   localparam int CSR_W   = 2;
   localparam int REQ_W   = 88;
   localparam int RSP_W   = 64;

   localparam logic [CSR_W-1:0] CSR_ANGLE_NOISE = 2'd0;
   localparam logic [CSR_W-1:0] CSR_BIAS_NOISE  = 2'd1;
   localparam logic [CSR_W-1:0] CSR_MEAS_NOISE  = 2'd2;

   localparam logic [NOISE_W-1:0] ANGLE_NOISE_RST = 21'd1049;
   localparam logic [NOISE_W-1:0] BIAS_NOISE_RST  = 21'd3146;
   localparam logic [MEAS_W-1:0]  MEAS_NOISE_RST  = 31'd524288;
   localparam logic signed [DATA_W-1:0] ONE_FX    = 32'sd1048576;

   typedef enum logic [4:0] {
      OP_NONE, OP_DIFF_RATE, OP_MUL_RATE_DT, OP_ANGLE_PRED, OP_PAA_Q, OP_PCROSS_SUM,
      OP_MUL_CROSS_DT, OP_P00, OP_MUL_PBB_DT, OP_P01, OP_P10, OP_P11, OP_S,
      OP_DIV0_START, OP_DIV0_WAIT, OP_DIV1_START, OP_DIV1_WAIT, OP_Y,
      OP_MUL_K0_Y, OP_ANGLE_UPD, OP_MUL_K1_Y, OP_BIAS_UPD,
      OP_MUL_K0_P00, OP_PAA_UPD, OP_MUL_K0_P01, OP_PAB_UPD,
      OP_MUL_K1_P00, OP_PBA_UPD, OP_MUL_K1_P01, OP_PBB_UPD, OP_RESULT
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DIFF_RATE, ST_MUL_RATE_DT, ST_ANGLE_PRED, ST_PAA_Q, ST_PCROSS_SUM,
      ST_MUL_CROSS_DT, ST_P00, ST_MUL_PBB_DT, ST_P01, ST_P10, ST_P11, ST_S,
      ST_DIV0_START, ST_DIV0_WAIT, ST_DIV1_START, ST_DIV1_WAIT, ST_Y,
      ST_MUL_K0_Y, ST_ANGLE_UPD, ST_MUL_K1_Y, ST_BIAS_UPD,
      ST_MUL_K0_P00, ST_PAA_UPD, ST_MUL_K0_P01, ST_PAB_UPD,
      ST_MUL_K1_P00, ST_PBA_UPD, ST_MUL_K1_P01, ST_PBB_UPD, ST_RESULT
   } state_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic s_pos;
      logic out_free;
   } status_type;

   // magnitude to signed, clamped to the signed range
   function automatic logic signed [DATA_W-1:0] sat_mag(input logic [63:0] m, input logic neg);
      logic [63:0] lim;
      logic [63:0] c;
      lim = neg ? (64'd1 << (DATA_W-1)) : ((64'd1 << (DATA_W-1)) - 64'd1);
      c = (m > lim) ? lim : m;
      sat_mag = neg ? DATA_W'(-c) : DATA_W'(c);
   endfunction

   function automatic logic signed [DATA_W-1:0] sat_add(input logic signed [DATA_W-1:0] a,
                                                        input logic signed [DATA_W-1:0] b,
                                                        input logic sub);
      logic signed [DATA_W:0] s;
      s = sub ? ((DATA_W+1)'(a) - (DATA_W+1)'(b)) : ((DATA_W+1)'(a) + (DATA_W+1)'(b));
      if (s[DATA_W] != s[DATA_W-1]) begin
         sat_add = s[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end else begin
         sat_add = s[DATA_W-1:0];
      end
   endfunction

endpackage

FILE: rtl/tak_div.sv
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter serial divider
// Restoring divider, one quotient bit per cycle, fixed-point quotient
// truncated toward zero and saturated.
// ----------------------------------------------------------------------------
module tak_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [tak_pkg::DATA_W-1:0]   num,
   input  logic signed [tak_pkg::DATA_W-1:0]   den,
   output logic                                done,
   output logic signed [tak_pkg::DATA_W-1:0]   quot
);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [tak_pkg::CNT_W-1:0]     cnt_ff, cnt_in;
   logic [tak_pkg::DVD_W-1:0]     dvd_ff, dvd_in;
   logic [tak_pkg::DVD_W-1:0]     q_ff, q_in;
   logic [tak_pkg::DATA_W-2:0]    rem_ff, rem_in;
   logic                          neg_ff, neg_in;
   logic [tak_pkg::DATA_W-1:0]    rem_shift;
   logic [tak_pkg::DATA_W-1:0]    num_mag;
   logic                          qbit;

   always_comb begin
      num_mag   = num[tak_pkg::DATA_W-1] ? tak_pkg::DATA_W'(-num) : tak_pkg::DATA_W'(num);
      rem_shift = {rem_ff, dvd_ff[tak_pkg::DVD_W-1]};
      qbit      = rem_shift >= {1'b0, den[tak_pkg::DATA_W-2:0]};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = {num_mag, {tak_pkg::FRAC_W{1'b0}}};
         q_in    = '0;
         rem_in  = '0;
         neg_in  = num[tak_pkg::DATA_W-1];
      end else if (busy_ff) begin
         rem_in = qbit ? (tak_pkg::DATA_W-1)'(rem_shift - {1'b0, den[tak_pkg::DATA_W-2:0]})
                       : rem_shift[tak_pkg::DATA_W-2:0];
         q_in   = {q_ff[tak_pkg::DVD_W-2:0], qbit};
         dvd_in = {dvd_ff[tak_pkg::DVD_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tak_pkg::CNT_W'(tak_pkg::DVD_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      rem_ff <= rem_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = tak_pkg::sat_mag({{(64-tak_pkg::DVD_W){1'b0}}, q_ff}, neg_ff);

endmodule

FILE: rtl/tak_datapath.sv
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter datapath
// Filter state, covariance, temporaries, one shared multiplier, one
// saturating adder, the gain divider and the result register.
// ----------------------------------------------------------------------------
module tak_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  tak_pkg::cmd_type                    cmd,
   output tak_pkg::status_type                 status,
   input  logic                                csr_we,
   input  logic [tak_pkg::CSR_W-1:0]           csr_index,
   input  logic [tak_pkg::MEAS_W-1:0]          csr_wdata,
   input  logic signed [tak_pkg::DATA_W-1:0]   accel_angle,
   input  logic signed [tak_pkg::DATA_W-1:0]   gyro_rate,
   input  logic [tak_pkg::DT_W-1:0]            time_step,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic signed [tak_pkg::DATA_W-1:0]   angle_estimate,
   output logic signed [tak_pkg::DATA_W-1:0]   bias_estimate
);

   localparam int W = tak_pkg::DATA_W;
   typedef logic signed [W-1:0] word_type;

   logic [tak_pkg::NOISE_W-1:0] qa_ff, qg_ff;
   logic [tak_pkg::MEAS_W-1:0]  r_ff;
   word_type acc_ff, gyro_ff;
   logic [tak_pkg::DT_W-1:0] dt_ff;
   word_type angle_ff, bias_ff, paa_ff, pab_ff, pba_ff, pbb_ff;
   word_type tmp_ff, tmp2_ff, p00_ff, p01_ff, p10_ff, p11_ff, s_ff, k0_ff, k1_ff, y_ff;
   word_type out_angle_ff, out_bias_ff;
   logic     out_valid_ff;
   logic [63:0] prod_ff;
   logic        prod_neg_ff;

   word_type mul_a, mul_b, add_a, add_b, sum, prodv;
   logic     add_sub;
   logic [W-1:0] mag_a, mag_b;
   logic [63:0] rnd;
   logic        div_start, div_done;
   word_type    div_num, div_quot;

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         tak_pkg::OP_MUL_RATE_DT:  begin mul_a = tmp_ff;  mul_b = W'(dt_ff); end
         tak_pkg::OP_MUL_CROSS_DT: begin mul_a = tmp2_ff; mul_b = W'(dt_ff); end
         // product held over for both cross terms
         tak_pkg::OP_MUL_PBB_DT,
         tak_pkg::OP_P01:          begin mul_a = pbb_ff;  mul_b = W'(dt_ff); end
         tak_pkg::OP_MUL_K0_Y:     begin mul_a = k0_ff;   mul_b = y_ff; end
         tak_pkg::OP_MUL_K1_Y:     begin mul_a = k1_ff;   mul_b = y_ff; end
         tak_pkg::OP_MUL_K0_P00:   begin mul_a = k0_ff;   mul_b = p00_ff; end
         tak_pkg::OP_MUL_K0_P01:   begin mul_a = k0_ff;   mul_b = p01_ff; end
         tak_pkg::OP_MUL_K1_P00:   begin mul_a = k1_ff;   mul_b = p00_ff; end
         tak_pkg::OP_MUL_K1_P01:   begin mul_a = k1_ff;   mul_b = p01_ff; end
         default: ;
      endcase
      mag_a = mul_a[W-1] ? W'(-mul_a) : W'(mul_a);
      mag_b = mul_b[W-1] ? W'(-mul_b) : W'(mul_b);
   end

   // round half away from zero on the magnitude
   always_comb begin
      rnd   = prod_ff + (64'd1 << (tak_pkg::FRAC_W - 1));
      prodv = tak_pkg::sat_mag(rnd >> tak_pkg::FRAC_W, prod_neg_ff);
   end

   always_comb begin
      add_a   = '0;
      add_b   = '0;
      add_sub = 1'b0;
      case (cmd.op)
         tak_pkg::OP_DIFF_RATE:  begin add_a = gyro_ff; add_b = bias_ff; add_sub = 1'b1; end
         tak_pkg::OP_ANGLE_PRED: begin add_a = angle_ff; add_b = prodv; end
         tak_pkg::OP_PAA_Q:      begin add_a = paa_ff; add_b = W'(qa_ff); end
         tak_pkg::OP_PCROSS_SUM: begin add_a = pab_ff; add_b = pba_ff; end
         tak_pkg::OP_P00:        begin add_a = tmp_ff; add_b = prodv; add_sub = 1'b1; end
         tak_pkg::OP_P01:        begin add_a = pab_ff; add_b = prodv; add_sub = 1'b1; end
         tak_pkg::OP_P10:        begin add_a = pba_ff; add_b = prodv; add_sub = 1'b1; end
         tak_pkg::OP_P11:        begin add_a = pbb_ff; add_b = W'(qg_ff); end
         tak_pkg::OP_S:          begin add_a = p00_ff; add_b = W'(r_ff); end
         tak_pkg::OP_Y:          begin add_a = acc_ff; add_b = angle_ff; add_sub = 1'b1; end
         tak_pkg::OP_ANGLE_UPD:  begin add_a = angle_ff; add_b = prodv; end
         tak_pkg::OP_BIAS_UPD:   begin add_a = bias_ff; add_b = prodv; end
         tak_pkg::OP_PAA_UPD:    begin add_a = p00_ff; add_b = prodv; add_sub = 1'b1; end
         tak_pkg::OP_PAB_UPD:    begin add_a = p01_ff; add_b = prodv; add_sub = 1'b1; end
         tak_pkg::OP_PBA_UPD:    begin add_a = p10_ff; add_b = prodv; add_sub = 1'b1; end
         tak_pkg::OP_PBB_UPD:    begin add_a = p11_ff; add_b = prodv; add_sub = 1'b1; end
         default: ;
      endcase
      sum = tak_pkg::sat_add(add_a, add_b, add_sub);
   end

   assign div_start = (cmd.op == tak_pkg::OP_DIV0_START) || (cmd.op == tak_pkg::OP_DIV1_START);
   assign div_num   = (cmd.op == tak_pkg::OP_DIV1_START) ? p10_ff : p00_ff;

   tak_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (s_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         qa_ff        <= tak_pkg::ANGLE_NOISE_RST;
         qg_ff        <= tak_pkg::BIAS_NOISE_RST;
         r_ff         <= tak_pkg::MEAS_NOISE_RST;
         angle_ff     <= '0;
         bias_ff      <= '0;
         paa_ff       <= tak_pkg::ONE_FX;
         pab_ff       <= '0;
         pba_ff       <= '0;
         pbb_ff       <= tak_pkg::ONE_FX;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tak_pkg::CSR_ANGLE_NOISE: qa_ff <= csr_wdata[tak_pkg::NOISE_W-1:0];
               tak_pkg::CSR_BIAS_NOISE:  qg_ff <= csr_wdata[tak_pkg::NOISE_W-1:0];
               tak_pkg::CSR_MEAS_NOISE:  r_ff  <= csr_wdata;
               default: ;
            endcase
         end
         case (cmd.op)
            tak_pkg::OP_ANGLE_PRED,
            tak_pkg::OP_ANGLE_UPD: angle_ff <= sum;
            tak_pkg::OP_BIAS_UPD:  bias_ff  <= sum;
            tak_pkg::OP_PAA_UPD:   paa_ff   <= sum;
            tak_pkg::OP_PAB_UPD:   pab_ff   <= sum;
            tak_pkg::OP_PBA_UPD:   pba_ff   <= sum;
            tak_pkg::OP_PBB_UPD:   pbb_ff   <= sum;
            default: ;
         endcase
         if (cmd.op == tak_pkg::OP_RESULT) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         acc_ff  <= accel_angle;
         gyro_ff <= gyro_rate;
         dt_ff   <= time_step;
      end
      prod_ff     <= 64'(mag_a) * 64'(mag_b);
      prod_neg_ff <= mul_a[W-1] ^ mul_b[W-1];
      case (cmd.op)
         tak_pkg::OP_DIFF_RATE,
         tak_pkg::OP_PAA_Q:      tmp_ff  <= sum;
         tak_pkg::OP_PCROSS_SUM: tmp2_ff <= sum;
         tak_pkg::OP_P00:        p00_ff  <= sum;
         tak_pkg::OP_P01:        p01_ff  <= sum;
         tak_pkg::OP_P10:        p10_ff  <= sum;
         tak_pkg::OP_P11:        p11_ff  <= sum;
         tak_pkg::OP_Y:          y_ff    <= sum;
         tak_pkg::OP_S: begin
            s_ff  <= sum;
            k0_ff <= '0;
            k1_ff <= '0;
         end
         tak_pkg::OP_DIV0_WAIT: if (div_done) k0_ff <= div_quot;
         tak_pkg::OP_DIV1_WAIT: if (div_done) k1_ff <= div_quot;
         tak_pkg::OP_RESULT: begin
            out_angle_ff <= angle_ff;
            out_bias_ff  <= bias_ff;
         end
         default: ;
      endcase
   end

   assign status.div_done = div_done;
   assign status.s_pos    = !s_ff[W-1] && (s_ff != '0);
   assign status.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid     = out_valid_ff;
   assign angle_estimate = out_angle_ff;
   assign bias_estimate  = out_bias_ff;

endmodule

FILE: rtl/tak_ctrl.sv
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter controller
// Steps the datapath through predict, gain and correction for one beat.
// ----------------------------------------------------------------------------
module tak_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tak_pkg::status_type   status,
   output tak_pkg::cmd_type      cmd
);

   tak_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tak_pkg::ST_IDLE:         if (req_tvalid) state_in = tak_pkg::ST_DIFF_RATE;
         tak_pkg::ST_DIFF_RATE:    state_in = tak_pkg::ST_MUL_RATE_DT;
         tak_pkg::ST_MUL_RATE_DT:  state_in = tak_pkg::ST_ANGLE_PRED;
         tak_pkg::ST_ANGLE_PRED:   state_in = tak_pkg::ST_PAA_Q;
         tak_pkg::ST_PAA_Q:        state_in = tak_pkg::ST_PCROSS_SUM;
         tak_pkg::ST_PCROSS_SUM:   state_in = tak_pkg::ST_MUL_CROSS_DT;
         tak_pkg::ST_MUL_CROSS_DT: state_in = tak_pkg::ST_P00;
         tak_pkg::ST_P00:          state_in = tak_pkg::ST_MUL_PBB_DT;
         tak_pkg::ST_MUL_PBB_DT:   state_in = tak_pkg::ST_P01;
         tak_pkg::ST_P01:          state_in = tak_pkg::ST_P10;
         tak_pkg::ST_P10:          state_in = tak_pkg::ST_P11;
         tak_pkg::ST_P11:          state_in = tak_pkg::ST_S;
         tak_pkg::ST_S:            state_in = tak_pkg::ST_DIV0_START;
         tak_pkg::ST_DIV0_START:   state_in = status.s_pos ? tak_pkg::ST_DIV0_WAIT
                                                           : tak_pkg::ST_Y;
         tak_pkg::ST_DIV0_WAIT:    if (status.div_done) state_in = tak_pkg::ST_DIV1_START;
         tak_pkg::ST_DIV1_START:   state_in = tak_pkg::ST_DIV1_WAIT;
         tak_pkg::ST_DIV1_WAIT:    if (status.div_done) state_in = tak_pkg::ST_Y;
         tak_pkg::ST_Y:            state_in = tak_pkg::ST_MUL_K0_Y;
         tak_pkg::ST_MUL_K0_Y:     state_in = tak_pkg::ST_ANGLE_UPD;
         tak_pkg::ST_ANGLE_UPD:    state_in = tak_pkg::ST_MUL_K1_Y;
         tak_pkg::ST_MUL_K1_Y:     state_in = tak_pkg::ST_BIAS_UPD;
         tak_pkg::ST_BIAS_UPD:     state_in = tak_pkg::ST_MUL_K0_P00;
         tak_pkg::ST_MUL_K0_P00:   state_in = tak_pkg::ST_PAA_UPD;
         tak_pkg::ST_PAA_UPD:      state_in = tak_pkg::ST_MUL_K0_P01;
         tak_pkg::ST_MUL_K0_P01:   state_in = tak_pkg::ST_PAB_UPD;
         tak_pkg::ST_PAB_UPD:      state_in = tak_pkg::ST_MUL_K1_P00;
         tak_pkg::ST_MUL_K1_P00:   state_in = tak_pkg::ST_PBA_UPD;
         tak_pkg::ST_PBA_UPD:      state_in = tak_pkg::ST_MUL_K1_P01;
         tak_pkg::ST_MUL_K1_P01:   state_in = tak_pkg::ST_PBB_UPD;
         tak_pkg::ST_PBB_UPD:      state_in = tak_pkg::ST_RESULT;
         tak_pkg::ST_RESULT:       if (status.out_free) state_in = tak_pkg::ST_IDLE;
         default:                  state_in = tak_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd.load   = 1'b0;
      cmd.op     = tak_pkg::OP_NONE;
      case (state_ff)
         tak_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         tak_pkg::ST_DIFF_RATE:    cmd.op = tak_pkg::OP_DIFF_RATE;
         tak_pkg::ST_MUL_RATE_DT:  cmd.op = tak_pkg::OP_MUL_RATE_DT;
         tak_pkg::ST_ANGLE_PRED:   cmd.op = tak_pkg::OP_ANGLE_PRED;
         tak_pkg::ST_PAA_Q:        cmd.op = tak_pkg::OP_PAA_Q;
         tak_pkg::ST_PCROSS_SUM:   cmd.op = tak_pkg::OP_PCROSS_SUM;
         tak_pkg::ST_MUL_CROSS_DT: cmd.op = tak_pkg::OP_MUL_CROSS_DT;
         tak_pkg::ST_P00:          cmd.op = tak_pkg::OP_P00;
         tak_pkg::ST_MUL_PBB_DT:   cmd.op = tak_pkg::OP_MUL_PBB_DT;
         tak_pkg::ST_P01:          cmd.op = tak_pkg::OP_P01;
         tak_pkg::ST_P10:          cmd.op = tak_pkg::OP_P10;
         tak_pkg::ST_P11:          cmd.op = tak_pkg::OP_P11;
         tak_pkg::ST_S:            cmd.op = tak_pkg::OP_S;
         tak_pkg::ST_DIV0_START:   cmd.op = status.s_pos ? tak_pkg::OP_DIV0_START
                                                         : tak_pkg::OP_NONE;
         tak_pkg::ST_DIV0_WAIT:    cmd.op = tak_pkg::OP_DIV0_WAIT;
         tak_pkg::ST_DIV1_START:   cmd.op = tak_pkg::OP_DIV1_START;
         tak_pkg::ST_DIV1_WAIT:    cmd.op = tak_pkg::OP_DIV1_WAIT;
         tak_pkg::ST_Y:            cmd.op = tak_pkg::OP_Y;
         tak_pkg::ST_MUL_K0_Y:     cmd.op = tak_pkg::OP_MUL_K0_Y;
         tak_pkg::ST_ANGLE_UPD:    cmd.op = tak_pkg::OP_ANGLE_UPD;
         tak_pkg::ST_MUL_K1_Y:     cmd.op = tak_pkg::OP_MUL_K1_Y;
         tak_pkg::ST_BIAS_UPD:     cmd.op = tak_pkg::OP_BIAS_UPD;
         tak_pkg::ST_MUL_K0_P00:   cmd.op = tak_pkg::OP_MUL_K0_P00;
         tak_pkg::ST_PAA_UPD:      cmd.op = tak_pkg::OP_PAA_UPD;
         tak_pkg::ST_MUL_K0_P01:   cmd.op = tak_pkg::OP_MUL_K0_P01;
         tak_pkg::ST_PAB_UPD:      cmd.op = tak_pkg::OP_PAB_UPD;
         tak_pkg::ST_MUL_K1_P00:   cmd.op = tak_pkg::OP_MUL_K1_P00;
         tak_pkg::ST_PBA_UPD:      cmd.op = tak_pkg::OP_PBA_UPD;
         tak_pkg::ST_MUL_K1_P01:   cmd.op = tak_pkg::OP_MUL_K1_P01;
         tak_pkg::ST_PBB_UPD:      cmd.op = tak_pkg::OP_PBB_UPD;
         tak_pkg::ST_RESULT:       cmd.op = status.out_free ? tak_pkg::OP_RESULT
                                                            : tak_pkg::OP_NONE;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tak_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/tilt_angle_kalman_filter.sv
// ----------------------------------------------------------------------------
// Tilt angle Kalman filter
// Two-state angle and gyro bias filter, signed Q12.20, saturating.
// ----------------------------------------------------------------------------
// One request beat gives one response beat. After acceptance the result is
// built in 28 sequencer steps around one shared multiplier and adder, plus
// two waits on the serial gain divider; when the gain denominator is not
// positive the divider and its waits are skipped. The next request is taken
// in the cycle after the result is loaded into the response register, even
// while it waits there.
module tilt_angle_kalman_filter (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tak_pkg::REQ_W-1:0]     req_tdata,  // accel_angle, gyro_rate, time_step
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [tak_pkg::RSP_W-1:0]     rsp_tdata,  // angle_estimate, bias_estimate
   input  logic                          csr_we,
   input  logic [tak_pkg::CSR_W-1:0]     csr_index,
   input  logic [tak_pkg::MEAS_W-1:0]    csr_wdata
);

   tak_pkg::cmd_type    cmd;
   tak_pkg::status_type status;
   logic signed [tak_pkg::DATA_W-1:0] angle_estimate, bias_estimate;

   tak_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tak_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .accel_angle    (req_tdata[31:0]),
      .gyro_rate      (req_tdata[63:32]),
      .time_step      (req_tdata[84:64]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .angle_estimate (angle_estimate),
      .bias_estimate  (bias_estimate)
   );

   assign rsp_tdata = {bias_estimate, angle_estimate};

endmodule
